// ===== rtl/lpt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpt_pkg
// Types, character codes, colour level tables and helper functions shared
// by the lighting pattern text parser.
// ----------------------------------------------------------------------------
package lpt_pkg;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_NUMBER = 3'd1,
		PH_RED    = 3'd2,
		PH_GREEN  = 3'd3,
		PH_BLUE   = 3'd4
	} phase_t;

	localparam logic [7:0] CH_HOLD_END  = 8'd41;   // ')'
	localparam logic [7:0] CH_FIELD_END = 8'd91;   // '['
	localparam logic [7:0] CH_BLUE_END  = 8'd124;  // '|'
	localparam logic [7:0] CH_ZERO      = 8'd48;   // '0'
	localparam logic [7:0] CH_NINE      = 8'd57;   // '9'

	localparam logic [16:0] RG_THRESHOLD = 17'd19;
	localparam logic [16:0] B_THRESHOLD  = 17'd43;

	localparam logic [30:0] NUM_MAX   = 31'h7FFF_FFFF;
	localparam logic [15:0] COLOR_MAX = 16'hFFFF;
	localparam logic [6:0]  CHAN_MAX  = 7'd127;

	localparam logic [7:0] RG_LEVELS [8] = '{8'd0, 8'd37, 8'd74, 8'd111,
		8'd148, 8'd185, 8'd222, 8'd255};
	localparam logic [7:0] B_LEVELS [4] = '{8'd0, 8'd85, 8'd170, 8'd255};

	localparam logic ENTRY_HOLD  = 1'b0;
	localparam logic ENTRY_WRITE = 1'b1;

	typedef struct packed {
		logic [7:0] text_char;
		logic       file_start;
	} item_t;

	typedef struct packed {
		logic        entry_kind;
		logic [4:0]  pattern_number;
		logic [6:0]  channel;
		logic [7:0]  color_code;
		logic [30:0] hold_time_ms;
		logic        channel_bad;
		logic        pattern_full;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} result_t;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Decimal digits '0' to '9' carry their value in the low nibble.
	function automatic logic [30:0] acc_number(logic [30:0] acc, logic [7:0] c);
		logic [34:0] v;
		v = 35'(acc) * 35'd10 + 35'(c[3:0]);
		return (v > 35'(NUM_MAX)) ? NUM_MAX : v[30:0];
	endfunction

	function automatic logic [15:0] acc_color(logic [15:0] acc, logic [7:0] c);
		logic [19:0] v;
		v = 20'(acc) * 20'd10 + 20'(c[3:0]);
		return (v > 20'(COLOR_MAX)) ? COLOR_MAX : v[15:0];
	endfunction

	// The last level within the threshold wins; no match gives level zero.
	function automatic logic [2:0] quant_rg(logic [15:0] v);
		logic [2:0]  pick;
		logic [16:0] delta;
		pick = '0;
		for (int i = 0; i < 8; i++) begin
			if (v >= 16'(RG_LEVELS[i]))
				delta = 17'(v) - 17'(RG_LEVELS[i]);
			else
				delta = 17'(RG_LEVELS[i]) - 17'(v);
			if (delta < RG_THRESHOLD)
				pick = 3'(i);
		end
		return pick;
	endfunction

	function automatic logic [1:0] quant_b(logic [15:0] v);
		logic [1:0]  pick;
		logic [16:0] delta;
		pick = '0;
		for (int i = 0; i < 4; i++) begin
			if (v >= 16'(B_LEVELS[i]))
				delta = 17'(v) - 17'(B_LEVELS[i]);
			else
				delta = 17'(B_LEVELS[i]) - 17'(v);
			if (delta < B_THRESHOLD)
				pick = 2'(i);
		end
		return pick;
	endfunction

endpackage

// ===== rtl/lpt_if.sv =====
// ----------------------------------------------------------------------------
// lpt_if
// Valid/ready channels of the parser: text characters in, table entries out.
// ----------------------------------------------------------------------------
interface lpt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       file_start;

	modport source (output valid, output text_char, output file_start, input ready);
	modport sink (input valid, input text_char, input file_start, output ready);
endinterface

interface lpt_entry_if;
	logic        valid;
	logic        ready;
	logic        entry_kind;
	logic [4:0]  pattern_number;
	logic [6:0]  channel;
	logic [7:0]  color_code;
	logic [30:0] hold_time_ms;
	logic        channel_bad;
	logic        pattern_full;

	modport source (output valid, output entry_kind, output pattern_number,
		output channel, output color_code, output hold_time_ms,
		output channel_bad, output pattern_full, input ready);
	modport sink (input valid, input entry_kind, input pattern_number,
		input channel, input color_code, input hold_time_ms,
		input channel_bad, input pattern_full, output ready);
endinterface

// ===== rtl/lpt_parser.sv =====
// ----------------------------------------------------------------------------
// lpt_parser
// Parser state and the per-character state update. Produces at most one
// entry for the registered character and commits the update on advance.
// ----------------------------------------------------------------------------
module lpt_parser #(
	parameter int CHANNEL_COUNT = 108,
	parameter int MAX_PATTERNS  = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lpt_pkg::item_t  item,
	input  logic            advance,
	output lpt_pkg::result_t result
);
	import lpt_pkg::*;

	localparam logic [4:0]  PAT_LAST = 5'(MAX_PATTERNS - 1);
	localparam logic [30:0] CHAN_LIMIT = 31'(CHANNEL_COUNT);

	phase_t      phase_q, phase_d, phase_c;
	logic [30:0] number_q, number_d, number_c;
	logic [15:0] color_q, color_d, color_c;
	logic [2:0]  red_q, red_d, red_c;
	logic [2:0]  green_q, green_d, green_c;
	logic [4:0]  pattern_q, pattern_d, pattern_c;
	logic        full;
	logic        digit;
	logic [7:0]  c;

	assign c = item.text_char;
	assign digit = is_digit(c);

	// A file start sees the reset state before this character.
	always_comb begin
		if (item.file_start) begin
			phase_c   = PH_IDLE;
			number_c  = '0;
			color_c   = '0;
			red_c     = '0;
			green_c   = '0;
			pattern_c = '0;
		end else begin
			phase_c   = phase_q;
			number_c  = number_q;
			color_c   = color_q;
			red_c     = red_q;
			green_c   = green_q;
			pattern_c = pattern_q;
		end
	end

	assign full = pattern_c >= PAT_LAST;

	// Next state
	always_comb begin
		phase_d   = phase_c;
		number_d  = number_c;
		color_d   = color_c;
		red_d     = red_c;
		green_d   = green_c;
		pattern_d = pattern_c;
		unique case (phase_c) inside
			PH_NUMBER: begin
				if (digit) begin
					number_d = acc_number(number_c, c);
				end else if (c == CH_HOLD_END) begin
					if (!full)
						pattern_d = pattern_c + 5'd1;
					phase_d = PH_IDLE;
				end else begin
					color_d = '0;
					phase_d = PH_RED;
				end
			end
			PH_RED, PH_GREEN: begin
				if (c == CH_FIELD_END) begin
					if (phase_c == PH_RED) begin
						red_d   = quant_rg(color_c);
						phase_d = PH_GREEN;
					end else begin
						green_d = quant_rg(color_c);
						phase_d = PH_BLUE;
					end
					color_d = '0;
				end else if (digit) begin
					color_d = acc_color(color_c, c);
				end
			end
			PH_BLUE: begin
				if (c == CH_BLUE_END) begin
					color_d = '0;
					phase_d = PH_IDLE;
				end else if (digit) begin
					color_d = acc_color(color_c, c);
				end
			end
			default: begin
				if (digit) begin
					number_d = 31'(c[3:0]);
					phase_d  = PH_NUMBER;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	// Outputs
	always_comb begin
		result = '0;
		result.entry.pattern_number = pattern_c;
		result.entry.pattern_full   = full;
		unique case (phase_c)
			PH_NUMBER: begin
				if (!digit && c == CH_HOLD_END) begin
					result.valid              = 1'b1;
					result.entry.entry_kind   = ENTRY_HOLD;
					result.entry.hold_time_ms = number_c;
				end
			end
			PH_BLUE: begin
				if (c == CH_BLUE_END) begin
					result.valid            = 1'b1;
					result.entry.entry_kind = ENTRY_WRITE;
					result.entry.channel    = (number_c > 31'(CHAN_MAX)) ?
						CHAN_MAX : number_c[6:0];
					result.entry.color_code = {red_c, green_c, quant_b(color_c)};
					result.entry.channel_bad = number_c >= CHAN_LIMIT;
				end
			end
			default: begin
				result.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			number_q  <= '0;
			color_q   <= '0;
			red_q     <= '0;
			green_q   <= '0;
			pattern_q <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			number_q  <= number_d;
			color_q   <= color_d;
			red_q     <= red_d;
			green_q   <= green_d;
			pattern_q <= pattern_d;
		end
	end

endmodule

// ===== rtl/lighting_pattern_text_parser.sv =====
// ----------------------------------------------------------------------------
// lighting_pattern_text_parser
// Parses lighting pattern text into hold-time and channel colour entries.
// ----------------------------------------------------------------------------
// The block takes one character per transfer and sustains one transfer per
// clock cycle in both directions while the output is not stalled. A
// character is registered on input, the parser state update and the entry it
// may produce are computed combinationally from that register, and an entry
// is loaded into the output register when its character advances. The
// single parser state update per character sets the rate; a stalled output
// holds one entry while the input register still absorbs characters that
// produce none.
module lighting_pattern_text_parser #(
	parameter int CHANNEL_COUNT = 108,
	parameter int MAX_PATTERNS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	lpt_text_if.sink           text,
	lpt_entry_if.source        entry
);
	import lpt_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	logic    advance;
	entry_t  entry_q;
	logic    out_valid_q;

	// The registered character moves on unless its entry finds the output full and not ready.
	assign advance = valid_s1 && (!result.valid || !out_valid_q || entry.ready);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1.text_char  <= text.text_char;
			item_s1.file_start <= text.file_start;
		end
	end

	lpt_parser #(
		.CHANNEL_COUNT (CHANNEL_COUNT),
		.MAX_PATTERNS  (MAX_PATTERNS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result.valid) begin
			out_valid_q <= 1'b1;
		end else if (entry.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid)
			entry_q <= result.entry;
	end

	assign entry.valid          = out_valid_q;
	assign entry.entry_kind     = entry_q.entry_kind;
	assign entry.pattern_number = entry_q.pattern_number;
	assign entry.channel        = entry_q.channel;
	assign entry.color_code     = entry_q.color_code;
	assign entry.hold_time_ms   = entry_q.hold_time_ms;
	assign entry.channel_bad    = entry_q.channel_bad;
	assign entry.pattern_full   = entry_q.pattern_full;

endmodule
